/* design/share_mode_admission_table_top_macros.svh */
// Assertion macros for the share-mode admission table.
// Used by share_mode_admission_table_top; no other dependencies.
`ifndef SHARE_MODE_ADMISSION_TABLE_TOP_MACROS_SVH
`define SHARE_MODE_ADMISSION_TABLE_TOP_MACROS_SVH

`ifndef SYNTH
`define SMAT_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("share mode table assertion failed");
`define SMAT_ASSERT(lbl, prop) `SMAT_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define SMAT_ASSERT_CLK(lbl, clk, rst_n, prop)
`define SMAT_ASSERT(lbl, prop)
`endif

`endif

/* design/smat_pkg.sv */
// Shared constants and types of the share-mode admission table.
// No dependencies; used by share_mode_admission_table_top.
package smat_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COUNT_BITS_DEF  = 8;

  localparam int KEY_BITS = 32;
  localparam int MODE_W   = 10;

  // operation codes
  localparam logic [1:0] OP_REMOVE = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;

  // access mode bit positions
  localparam int MB_READ       = 0;
  localparam int MB_WRITE      = 1;
  localparam int MB_DENY_READ  = 2;
  localparam int MB_DENY_WRITE = 3;
  localparam int MB_LOCK       = 8;
  localparam int MB_SHARED     = 9;

  // count slots in a packed counts word
  localparam int CNT_RD  = 0;
  localparam int CNT_WR  = 1;
  localparam int CNT_DRD = 2;
  localparam int CNT_DWR = 3;
  localparam int CNT_LCK = 4;
  localparam int CNT_EXC = 5;
  localparam int NUM_CNT = 6;

  typedef enum logic [2:0] {
    STAT_GRANTED  = 3'd0,
    STAT_CONFLICT = 3'd1,
    STAT_ZERO     = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

endpackage

/* design/smat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instantiated by share_mode_admission_table_top.
module smat_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/share_mode_admission_table_top.sv */
// Share-mode admission table: open-file key table with share-mode use counts.
// Depends on smat_pkg, smat_ram and share_mode_admission_table_top_macros.svh.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the operation
//   (remove, add, test), tdata the device, file number and access mode.
//   Each request yields exactly one result on the m_axis channel: a status
//   code and the mode bits held on the entry before the request.
//   One request is in work at a time. A nonzero-mode request walks the key
//   memory one slot per cycle, then reads the counts memory, updates and
//   writes back; the key scan through the single read port of the key
//   memory sets how long such a request is in work. A zero-mode request
//   skips the scan and the counts memory and goes straight to the finish
//   state.
//   After reset the block clears the valid bits of the key memory, one slot
//   a cycle, over all slots; s_axis_tready_o stays low meanwhile.
//   The result sits in an output register; a new request is accepted while
//   it waits. If the receiver stalls, the next result is held inside and no
//   further request is accepted until the output register frees.
module share_mode_admission_table_top #(
  parameter int TABLE_DEPTH = smat_pkg::TABLE_DEPTH_DEF,
  parameter int COUNT_BITS  = smat_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] device_id, [63:32] inode_number, [73:64] access_mode, [79:74] zero
  input  logic [79:0] s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] status, [12:3] held_mode, [15:13] zero
  output logic [15:0] m_axis_tdata_o
);

`include "share_mode_admission_table_top_macros.svh"

  localparam int IdxW  = $clog2(TABLE_DEPTH);
  localparam int KB    = smat_pkg::KEY_BITS;
  localparam int KeyW  = 2 * KB + 1;
  localparam int CW    = COUNT_BITS;
  localparam int CntW  = smat_pkg::NUM_CNT * CW;
  localparam int MW    = smat_pkg::MODE_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0]   CntMax  = {CW{1'b1}};
  localparam logic [CW-1:0]   CntOne  = CW'(1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_TAIL, S_RDCNT, S_MODIFY, S_FINISH
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     scan_q;
  logic                chk_vld_q;
  logic                hit_found_q, spare_found_q;
  logic [IdxW-1:0]     hit_idx_q, spare_idx_q, wr_idx_q;
  logic [1:0]          req_op_q;
  logic [KB-1:0]       req_dev_q, req_ino_q;
  logic [MW-1:0]       req_mode_q;
  smat_pkg::status_e   res_status_q;
  logic [MW-1:0]       res_held_q;
  logic                key_we_q, key_valid_q, cnt_we_q;
  logic [CntW-1:0]     cnt_wdata_q;
  logic                m_valid_q;
  logic [15:0]         m_data_q;

  logic                key_we, cnt_we, out_free, in_acc;
  logic [IdxW-1:0]     key_waddr;
  logic [KeyW-1:0]     key_wdata, key_rdata;
  logic [CntW-1:0]     cnt_rdata;
  logic                slot_v, key_match;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  assign key_we    = (state_q == S_CLEAR) || (state_q == S_FINISH && out_free && key_we_q);
  assign key_waddr = (state_q == S_CLEAR) ? scan_q : wr_idx_q;
  assign key_wdata = (state_q == S_CLEAR) ? '0 : {key_valid_q, req_dev_q, req_ino_q};
  assign cnt_we    = (state_q == S_FINISH) && out_free && cnt_we_q;

  smat_ram #(.WIDTH(KeyW), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (scan_q),
    .rdata_o (key_rdata)
  );

  smat_ram #(.WIDTH(CntW), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (wr_idx_q),
    .wdata_i (cnt_wdata_q),
    .raddr_i (hit_idx_q),
    .rdata_o (cnt_rdata)
  );

  assign slot_v    = key_rdata[KeyW-1];
  assign key_match = key_rdata[2*KB-1:0] == {req_dev_q, req_ino_q};

  // read-modify-write of one entry's counts
  logic [CW-1:0]     cur [smat_pkg::NUM_CNT];
  logic [CW-1:0]     nxt [smat_pkg::NUM_CNT];
  logic [MW-1:0]     held;
  logic              conflict, raises, idle_after;
  smat_pkg::status_e mod_status;
  logic              mod_key_we, mod_key_valid, mod_cnt_we;
  logic [IdxW-1:0]   mod_idx;
  logic [CntW-1:0]   mod_cnt;

  always_comb begin
    for (int k = 0; k < smat_pkg::NUM_CNT; k++) begin
      cur[k] = hit_found_q ? cnt_rdata[k*CW +: CW] : '0;
      nxt[k] = cur[k];
    end
    held = '0;
    held[smat_pkg::MB_READ]       = cur[smat_pkg::CNT_RD]  != '0;
    held[smat_pkg::MB_WRITE]      = cur[smat_pkg::CNT_WR]  != '0;
    held[smat_pkg::MB_DENY_READ]  = cur[smat_pkg::CNT_DRD] != '0;
    held[smat_pkg::MB_DENY_WRITE] = cur[smat_pkg::CNT_DWR] != '0;
    held[smat_pkg::MB_LOCK]       = cur[smat_pkg::CNT_LCK] != '0;
    held[smat_pkg::MB_SHARED]     = cur[smat_pkg::CNT_EXC] != '0;

    conflict =
      (req_mode_q[smat_pkg::MB_READ]       && held[smat_pkg::MB_DENY_READ])  ||
      (req_mode_q[smat_pkg::MB_WRITE]      && held[smat_pkg::MB_DENY_WRITE]) ||
      (req_mode_q[smat_pkg::MB_DENY_READ]  && held[smat_pkg::MB_READ])       ||
      (req_mode_q[smat_pkg::MB_DENY_WRITE] && held[smat_pkg::MB_WRITE])      ||
      (req_mode_q[smat_pkg::MB_LOCK]       && held[smat_pkg::MB_SHARED])     ||
      (req_mode_q[smat_pkg::MB_SHARED]     && held[smat_pkg::MB_LOCK]);
    raises = req_mode_q[smat_pkg::MB_READ] || req_mode_q[smat_pkg::MB_WRITE] ||
             req_mode_q[smat_pkg::MB_DENY_READ] || req_mode_q[smat_pkg::MB_DENY_WRITE] ||
             req_mode_q[smat_pkg::MB_LOCK];

    mod_status    = smat_pkg::STAT_GRANTED;
    mod_key_we    = 1'b0;
    mod_key_valid = 1'b1;
    mod_cnt_we    = 1'b0;
    mod_idx       = hit_idx_q;
    idle_after    = 1'b0;

    if (req_op_q == smat_pkg::OP_REMOVE) begin
      if (!hit_found_q) begin
        mod_status = smat_pkg::STAT_NOTFOUND;
      end else begin
        if (req_mode_q[smat_pkg::MB_READ] && cur[smat_pkg::CNT_RD] != '0)
          nxt[smat_pkg::CNT_RD] = cur[smat_pkg::CNT_RD] - CntOne;
        if (req_mode_q[smat_pkg::MB_WRITE] && cur[smat_pkg::CNT_WR] != '0)
          nxt[smat_pkg::CNT_WR] = cur[smat_pkg::CNT_WR] - CntOne;
        if (req_mode_q[smat_pkg::MB_DENY_READ] && cur[smat_pkg::CNT_DRD] != '0)
          nxt[smat_pkg::CNT_DRD] = cur[smat_pkg::CNT_DRD] - CntOne;
        if (req_mode_q[smat_pkg::MB_DENY_WRITE] && cur[smat_pkg::CNT_DWR] != '0)
          nxt[smat_pkg::CNT_DWR] = cur[smat_pkg::CNT_DWR] - CntOne;
        if (req_mode_q[smat_pkg::MB_LOCK] && cur[smat_pkg::CNT_LCK] != '0) begin
          nxt[smat_pkg::CNT_LCK] = cur[smat_pkg::CNT_LCK] - CntOne;
          if (cur[smat_pkg::CNT_LCK] == CntOne) nxt[smat_pkg::CNT_EXC] = '0;
        end
        idle_after = nxt[smat_pkg::CNT_RD] == '0 && nxt[smat_pkg::CNT_WR] == '0 &&
                     nxt[smat_pkg::CNT_DRD] == '0 && nxt[smat_pkg::CNT_DWR] == '0 &&
                     nxt[smat_pkg::CNT_LCK] == '0;
        mod_cnt_we    = 1'b1;
        mod_key_we    = idle_after;
        mod_key_valid = 1'b0;
      end
    end else if (conflict) begin
      mod_status = smat_pkg::STAT_CONFLICT;
    end else if (req_op_q == smat_pkg::OP_ADD && raises) begin
      if (!hit_found_q && !spare_found_q) begin
        mod_status = smat_pkg::STAT_FULL;
      end else begin
        if (!hit_found_q) begin
          mod_idx    = spare_idx_q;
          mod_key_we = 1'b1;
        end
        if (req_mode_q[smat_pkg::MB_READ] && cur[smat_pkg::CNT_RD] != CntMax)
          nxt[smat_pkg::CNT_RD] = cur[smat_pkg::CNT_RD] + CntOne;
        if (req_mode_q[smat_pkg::MB_WRITE] && cur[smat_pkg::CNT_WR] != CntMax)
          nxt[smat_pkg::CNT_WR] = cur[smat_pkg::CNT_WR] + CntOne;
        if (req_mode_q[smat_pkg::MB_DENY_READ] && cur[smat_pkg::CNT_DRD] != CntMax)
          nxt[smat_pkg::CNT_DRD] = cur[smat_pkg::CNT_DRD] + CntOne;
        if (req_mode_q[smat_pkg::MB_DENY_WRITE] && cur[smat_pkg::CNT_DWR] != CntMax)
          nxt[smat_pkg::CNT_DWR] = cur[smat_pkg::CNT_DWR] + CntOne;
        if (req_mode_q[smat_pkg::MB_LOCK]) begin
          if (cur[smat_pkg::CNT_LCK] != CntMax)
            nxt[smat_pkg::CNT_LCK] = cur[smat_pkg::CNT_LCK] + CntOne;
          if (!req_mode_q[smat_pkg::MB_SHARED] && cur[smat_pkg::CNT_EXC] != CntMax)
            nxt[smat_pkg::CNT_EXC] = cur[smat_pkg::CNT_EXC] + CntOne;
        end
        mod_cnt_we = 1'b1;
      end
    end

    for (int k = 0; k < smat_pkg::NUM_CNT; k++) begin
      mod_cnt[k*CW +: CW] = nxt[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      scan_q        <= '0;
      chk_vld_q     <= 1'b0;
      hit_found_q   <= 1'b0;
      spare_found_q <= 1'b0;
      key_we_q      <= 1'b0;
      cnt_we_q      <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      if (state_q == S_FINISH && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      if ((state_q == S_SCAN && chk_vld_q) || state_q == S_TAIL) begin
        if (slot_v && key_match && !hit_found_q) begin
          hit_found_q <= 1'b1;
          hit_idx_q   <= scan_q - IdxW'(1) + IdxW'(state_q == S_TAIL);
        end
        if (!slot_v && !spare_found_q) begin
          spare_found_q <= 1'b1;
          spare_idx_q   <= scan_q - IdxW'(1) + IdxW'(state_q == S_TAIL);
        end
      end

      unique case (state_q)
        S_CLEAR: begin
          if (scan_q == LastIdx) begin
            scan_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            scan_q <= scan_q + IdxW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            req_op_q      <= s_axis_tuser_i;
            req_dev_q     <= s_axis_tdata_i[KB-1:0];
            req_ino_q     <= s_axis_tdata_i[2*KB-1:KB];
            req_mode_q    <= s_axis_tdata_i[2*KB+MW-1:2*KB];
            hit_found_q   <= 1'b0;
            spare_found_q <= 1'b0;
            chk_vld_q     <= 1'b0;
            scan_q        <= '0;
            if (s_axis_tdata_i[2*KB+MW-1:2*KB] == '0) begin
              res_status_q <= smat_pkg::STAT_ZERO;
              res_held_q   <= '0;
              key_we_q     <= 1'b0;
              cnt_we_q     <= 1'b0;
              state_q      <= S_FINISH;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_vld_q <= 1'b1;
          if (scan_q == LastIdx) begin
            state_q <= S_TAIL;
          end else begin
            scan_q <= scan_q + IdxW'(1);
          end
        end
        S_TAIL: begin
          chk_vld_q <= 1'b0;
          state_q   <= S_RDCNT;
        end
        S_RDCNT: begin
          state_q <= S_MODIFY;
        end
        S_MODIFY: begin
          res_status_q <= mod_status;
          res_held_q   <= held;
          key_we_q     <= mod_key_we;
          key_valid_q  <= mod_key_valid;
          cnt_we_q     <= mod_cnt_we;
          cnt_wdata_q  <= mod_cnt;
          wr_idx_q     <= mod_idx;
          state_q      <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            m_data_q  <= {3'b000, res_held_q, res_status_q};
            scan_q    <= '0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `SMAT_ASSERT(a_result_from_finish, $rose(m_axis_tvalid_o) |-> $past(state_q == S_FINISH))
  `SMAT_ASSERT(a_key_write_state, key_we |-> (state_q == S_CLEAR || state_q == S_FINISH))
  `SMAT_ASSERT(a_full_only_when_no_slot,
    (state_q == S_FINISH && res_status_q == smat_pkg::STAT_FULL) |->
      (!hit_found_q && !spare_found_q))
  `SMAT_ASSERT(a_zero_mode_no_held,
    (m_axis_tvalid_o && m_axis_tdata_o[2:0] == smat_pkg::STAT_ZERO) |->
      (m_axis_tdata_o[12:3] == '0))

endmodule
